### sv/voice_slot_chain_allocator_unit_defines.svh
// assertion macros for the voice slot chain allocator
`ifndef VOICE_SLOT_CHAIN_ALLOCATOR_UNIT_DEFINES_SVH
`define VOICE_SLOT_CHAIN_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VSCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vsca_pkg.sv
// shared constants and types for the voice slot chain allocator
package vsca_pkg;

    localparam int NUM_SLOTS_DEF = 64;

    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = STAT_W;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL        = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_RELEASE = 2'd2;

    localparam int SCAN_CHUNK = 8;
    localparam int SCAN_ENC_W = $clog2(SCAN_CHUNK);

    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

### sv/vsca_link_ram.sv
// single write port, single registered read port link memory
module vsca_link_ram #(
    parameter int DEPTH = vsca_pkg::NUM_SLOTS_DEF,
    parameter int WIDTH = $clog2(vsca_pkg::NUM_SLOTS_DEF),
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    import vsca_pkg::*;

    logic [WIDTH-1:0] link_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/vsca_free_scan.sv
// lowest free slot search, one chunk of the active map per cycle
module vsca_free_scan #(
    parameter int NUM_SLOTS = vsca_pkg::NUM_SLOTS_DEF,
    localparam int SW       = $clog2(NUM_SLOTS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [NUM_SLOTS-1:0]   active,
    output vsca_pkg::scan_status_t status,
    output logic [SW-1:0]          free_idx
);
    import vsca_pkg::*;

    localparam int NCHUNK = (NUM_SLOTS + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PADW   = NCHUNK * SCAN_CHUNK;

    typedef enum logic {
        SC_IDLE,
        SC_RUN
    } scan_state_t;

    scan_state_t           state_reg;
    logic [CHW-1:0]        chunk_reg;
    logic                  done_reg;
    logic                  found_reg;
    logic [SW-1:0]         free_idx_reg;

    logic [PADW-1:0]       pad_vec;
    logic [SCAN_CHUNK-1:0] free_bits;
    logic [SCAN_ENC_W-1:0] enc;
    logic                  hit;
    logic                  last;

    always_comb begin
        pad_vec = '1;
        pad_vec[NUM_SLOTS-1:0] = active;
    end

    assign free_bits = ~pad_vec[chunk_reg*SCAN_CHUNK +: SCAN_CHUNK];
    assign hit       = |free_bits;
    assign last      = (chunk_reg == CHW'(NCHUNK - 1));

    // lowest free bit of the chunk
    always_comb begin
        enc = '0;
        for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                enc = SCAN_ENC_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            chunk_reg <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                SC_IDLE: begin
                    if (start) begin
                        chunk_reg <= '0;
                        state_reg <= SC_RUN;
                    end
                end
                SC_RUN: begin
                    if (hit || last) begin
                        done_reg     <= 1'b1;
                        found_reg    <= hit;
                        free_idx_reg <= SW'({chunk_reg, enc});
                        state_reg    <= SC_IDLE;
                    end else begin
                        chunk_reg <= chunk_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    assign status.done  = done_reg;
    assign status.found = found_reg;
    assign free_idx     = free_idx_reg;

endmodule

### sv/voice_slot_chain_allocator_unit.sv
// top level of the voice slot chain allocator
//
// requests come in on the s_ stream: s_tuser holds the operation (allocate or
// release) and s_tdata the slot to release. each request gives exactly one
// result on the m_ stream: m_tuser holds the status, m_tdata the slot, its
// chain neighbours, the tail flag and the active count.
// one request is worked on at a time; s_tready is high only while the
// sequencer is idle. the free slot search looks at eight slots a cycle and
// the link memories take one read and one write per cycle. an allocation
// on a non-empty pool searches chunk by chunk and links the found slot in
// after the tail, which it becomes; on a full pool every chunk is searched
// and the status is full. an allocation on an empty pool links slot 0 to
// itself. a release reads the slot's links and unlinks it, or empties the
// pool for the last active slot; a rejected release goes straight to its
// result. the result sits in an output register, so the next request is
// taken while a result waits; a stalled receiver holds the block at its
// final step. reset empties the pool at once; the link memories are not
// cleared, as an entry is always written before it is read.
`include "voice_slot_chain_allocator_unit_defines.svh"

module voice_slot_chain_allocator_unit #(
    parameter int NUM_SLOTS = vsca_pkg::NUM_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [5:0] slot_in
    input  logic [vsca_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  logic [vsca_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [5:0] slot_out, [11:6] prev_slot, [17:12] succ_slot, [18] was_tail,
    // [25:19] active_count
    output logic [vsca_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [vsca_pkg::M_TUSER_W-1:0] m_tuser
);
    import vsca_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_WRITE2,
        S_READ,
        S_UNLINK,
        S_DONE
    } seq_state_t;

    seq_state_t             state_reg;
    logic [NUM_SLOTS-1:0]   active_reg;
    logic [SW-1:0]          tail_reg;
    logic [CW-1:0]          count_reg;
    logic [SLOT_W-1:0]      sin_reg;
    logic [SW-1:0]          addr_reg;
    logic [SW-1:0]          cur_reg;
    logic [SW-1:0]          p_reg;
    logic [SW-1:0]          n_reg;

    logic [STAT_W-1:0]      res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic [SLOT_W-1:0]      res_prev_reg;
    logic [SLOT_W-1:0]      res_next_reg;
    logic                   res_tail_reg;
    logic [COUNT_W-1:0]     res_count_reg;

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;

    logic [SLOT_W-1:0]      in_slot;
    logic [SW-1:0]          in_idx;
    logic                   in_range;
    logic                   rel_ok;
    logic                   accept;
    logic                   scan_start;
    logic [SW-1:0]          rd_addr;
    logic [CW-1:0]          count_inc;
    logic [CW-1:0]          count_dec;
    logic                   rel_tail;

    logic                   prev_we;
    logic [SW-1:0]          prev_waddr;
    logic [SW-1:0]          prev_wdata;
    logic [SW-1:0]          prev_rd;
    logic                   next_we;
    logic [SW-1:0]          next_waddr;
    logic [SW-1:0]          next_wdata;
    logic [SW-1:0]          next_rd;

    scan_status_t           scan_st;
    logic [SW-1:0]          free_idx;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_slot    = s_tdata[SLOT_W-1:0];
    assign in_idx     = SW'(in_slot);
    assign in_range   = (32'(in_slot) < NUM_SLOTS);
    assign rel_ok     = (count_reg != '0) && in_range && active_reg[in_idx];
    assign scan_start = accept && (s_tuser[0] == OP_ALLOC) && (count_reg != '0);
    assign rd_addr    = (state_reg != S_IDLE) ? addr_reg :
                        ((s_tuser[0] == OP_RELEASE) ? in_idx : tail_reg);
    assign count_inc  = count_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;
    assign rel_tail   = (addr_reg == tail_reg);

    // link memory writes
    always_comb begin
        prev_we    = 1'b0;
        prev_waddr = cur_reg;
        prev_wdata = p_reg;
        next_we    = 1'b0;
        next_waddr = cur_reg;
        next_wdata = n_reg;
        case (state_reg)
            S_LINK: begin
                prev_we = 1'b1;
                next_we = 1'b1;
            end
            S_WRITE2: begin
                prev_we    = 1'b1;
                prev_waddr = n_reg;
                prev_wdata = cur_reg;
                next_we    = 1'b1;
                next_waddr = p_reg;
                next_wdata = cur_reg;
            end
            S_UNLINK: begin
                prev_we    = 1'b1;
                prev_waddr = n_reg;
                prev_wdata = p_reg;
                next_we    = 1'b1;
                next_waddr = p_reg;
                next_wdata = n_reg;
            end
            default: begin
                prev_we = 1'b0;
                next_we = 1'b0;
            end
        endcase
    end

    vsca_link_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (SW)
    ) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prev_we),
        .wr_addr (prev_waddr),
        .wr_data (prev_wdata),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    vsca_link_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (SW)
    ) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_we),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    vsca_free_scan #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_free_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .active   (active_reg),
        .status   (scan_st),
        .free_idx (free_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        sin_reg  <= in_slot;
                        addr_reg <= rd_addr;
                        if (s_tuser[0] == OP_ALLOC) begin
                            if (count_reg == '0) begin
                                // empty pool: slot 0 links to itself
                                cur_reg   <= '0;
                                p_reg     <= '0;
                                n_reg     <= '0;
                                state_reg <= S_LINK;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end else if (rel_ok) begin
                            state_reg <= S_READ;
                        end else begin
                            res_status_reg <= STAT_BAD_RELEASE;
                            res_slot_reg   <= in_slot;
                            res_prev_reg   <= '0;
                            res_next_reg   <= '0;
                            res_tail_reg   <= 1'b0;
                            res_count_reg  <= COUNT_W'(count_reg);
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_st.done) begin
                        if (scan_st.found) begin
                            cur_reg   <= free_idx;
                            p_reg     <= tail_reg;
                            n_reg     <= next_rd;
                            state_reg <= S_LINK;
                        end else begin
                            res_status_reg <= STAT_FULL;
                            res_slot_reg   <= '0;
                            res_prev_reg   <= '0;
                            res_next_reg   <= '0;
                            res_tail_reg   <= 1'b0;
                            res_count_reg  <= COUNT_W'(count_reg);
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_LINK: begin
                    state_reg <= S_WRITE2;
                end
                S_WRITE2: begin
                    active_reg[cur_reg] <= 1'b1;
                    tail_reg            <= cur_reg;
                    count_reg           <= count_inc;
                    res_status_reg      <= STAT_OK;
                    res_slot_reg        <= SLOT_W'(cur_reg);
                    res_prev_reg        <= SLOT_W'(p_reg);
                    res_next_reg        <= SLOT_W'(n_reg);
                    res_tail_reg        <= 1'b1;
                    res_count_reg       <= COUNT_W'(count_inc);
                    state_reg           <= S_DONE;
                end
                S_READ: begin
                    p_reg <= prev_rd;
                    n_reg <= next_rd;
                    if (count_reg == CW'(1)) begin
                        // last voice gone: the pool starts over
                        active_reg     <= '0;
                        tail_reg       <= '0;
                        count_reg      <= '0;
                        res_status_reg <= STAT_OK;
                        res_slot_reg   <= sin_reg;
                        res_prev_reg   <= SLOT_W'(prev_rd);
                        res_next_reg   <= SLOT_W'(next_rd);
                        res_tail_reg   <= rel_tail;
                        res_count_reg  <= '0;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_UNLINK;
                    end
                end
                S_UNLINK: begin
                    active_reg[addr_reg] <= 1'b0;
                    if (rel_tail) begin
                        tail_reg <= p_reg;
                    end
                    count_reg      <= count_dec;
                    res_status_reg <= STAT_OK;
                    res_slot_reg   <= sin_reg;
                    res_prev_reg   <= SLOT_W'(p_reg);
                    res_next_reg   <= SLOT_W'(n_reg);
                    res_tail_reg   <= rel_tail;
                    res_count_reg  <= COUNT_W'(count_dec);
                    state_reg      <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= M_TDATA_W'({res_count_reg, res_tail_reg,
                                                    res_next_reg, res_prev_reg,
                                                    res_slot_reg});
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `VSCA_ASSERT_NOW(a_count_matches_map, 1'b1, count_reg == CW'($countones(active_reg)), "active count disagrees with slot map")
    `VSCA_ASSERT_NOW(a_tail_active, count_reg != '0, active_reg[tail_reg], "tail slot is not active")
    `VSCA_ASSERT_NEXT(a_one_in_flight, accept, !s_tready, "request taken while another is in flight")

endmodule
